[src/fci_pkg.sv]
// ----------------------------------------------------------------------------
// fci_pkg
// Shared types and constants for the fan curve interpolator.
// ----------------------------------------------------------------------------
package fci_pkg;

  localparam int unsigned MAX_POINTS = 8;
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned SEG_W      = 3;
  localparam int unsigned TEMP_W     = 12;
  localparam int unsigned DUTY_W     = 15;
  localparam int unsigned Y_W        = 9;
  localparam int unsigned ACC_W      = 23;
  localparam int unsigned NUM_W      = 28;
  localparam int unsigned DIV_W      = 13;
  localparam int unsigned STEP_W     = 4;

  localparam logic [CNT_W-1:0]  MAX_CNT    = CNT_W'(MAX_POINTS);
  localparam logic [DUTY_W-1:0] FULL_SCALE = DUTY_W'(25600);
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(DUTY_W);
  localparam logic signed [Y_W-1:0] Y_FULL = Y_W'(100);

  localparam logic [1:0] REG_POINT_COUNT  = 2'd0;
  localparam logic [1:0] REG_CURVE_TEMPS  = 2'd1;
  localparam logic [1:0] REG_CURVE_SPEEDS = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL1,
    ST_MUL2,
    ST_PREP,
    ST_DIV,
    ST_DONE
  } state_e;

endpackage

[src/fan_curve_interpolator.sv]
// ----------------------------------------------------------------------------
// fan_curve_interpolator
// Piecewise linear fan curve evaluation over up to eight configured points.
// ----------------------------------------------------------------------------
// sequence: segment search, multiply steps ST_MUL1 and ST_MUL2 on the shared
//   multiplier, set-up, bit-serial divide, result; no bracketing segment, a flat
//   one or a non-positive product skips ahead to the result
// a new word is taken only in idle; busy_o stays high through the result strobe
// the result strobe done_o lasts one cycle and cannot be stalled
// reset: asynchronous, clears the sequencer and the curve registers
module fan_curve_interpolator
  import fci_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic [TEMP_W-1:0] temperature_i,
  output logic              done_o,
  output logic [DUTY_W-1:0] fan_duty_o,
  output logic              in_range_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_index_i,
  input  logic [63:0]       cfg_data_i
);

  state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q;
  logic [63:0]       temps_q, speeds_q;
  logic [TEMP_W-1:0] t_q, t_d;
  logic [SEG_W-1:0]  seg_q, seg_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic [TEMP_W-1:0] dw_q, dw_d;
  logic [DIV_W-1:0]  rem_q, rem_d;
  logic [DUTY_W-1:0] qp_q, qp_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DUTY_W-1:0] duty_q, duty_d;
  logic              inr_q, inr_d;

  // segment end points
  logic [SEG_W-1:0]  seg_nx;
  logic [7:0]        tb1, tb2, sb1, sb2;
  logic [TEMP_W-1:0] x1, x2, da, db, dx;
  logic signed [Y_W-1:0] y1, y2;
  logic [CNT_W-1:0]  n_pts;
  logic              seg_ok, bracket;

  // shared multiplier
  logic signed [Y_W-1:0]     mul_y;
  logic signed [TEMP_W:0]    mul_x;
  logic signed [ACC_W-1:0]   mul_p;

  // divider
  logic [NUM_W-1:0]  num;
  logic [DIV_W-1:0]  dvs;
  logic [DIV_W:0]    trial;
  logic              q_bit;

  assign seg_nx = seg_q + SEG_W'(1);
  assign tb1 = temps_q[{seg_q, 3'b000} +: 8];
  assign tb2 = temps_q[{seg_nx, 3'b000} +: 8];
  assign sb1 = speeds_q[{seg_q, 3'b000} +: 8];
  assign sb2 = speeds_q[{seg_nx, 3'b000} +: 8];
  assign x1  = {tb1, 4'b0000};
  assign x2  = {tb2, 4'b0000};
  assign y1  = Y_FULL - $signed({1'b0, sb1});
  assign y2  = Y_FULL - $signed({1'b0, sb2});
  assign da  = x2 - t_q;
  assign db  = t_q - x1;
  assign dx  = x2 - x1;

  assign n_pts   = (count_q > MAX_CNT) ? MAX_CNT : count_q;
  assign seg_ok  = ({1'b0, seg_q} + CNT_W'(1)) < n_pts;
  assign bracket = (x1 <= t_q) && (t_q <= x2);

  assign mul_y = (state_q == ST_MUL1) ? y1 : y2;
  assign mul_x = (state_q == ST_MUL1) ? $signed({1'b0, da}) : $signed({1'b0, db});
  assign mul_p = ACC_W'(mul_y * mul_x);

  assign num   = {acc_q[NUM_W-10:0], 9'b0} + NUM_W'(dw_q);
  assign dvs   = {dw_q, 1'b0};
  assign trial = {rem_q, qp_q[DUTY_W-1]};
  assign q_bit = trial >= {1'b0, dvs};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      temps_q  <= '0;
      speeds_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_POINT_COUNT:  count_q  <= cfg_data_i[CNT_W-1:0];
          REG_CURVE_TEMPS:  temps_q  <= cfg_data_i;
          REG_CURVE_SPEEDS: speeds_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    t_q    <= t_d;
    seg_q  <= seg_d;
    acc_q  <= acc_d;
    dw_q   <= dw_d;
    rem_q  <= rem_d;
    qp_q   <= qp_d;
    step_q <= step_d;
    duty_q <= duty_d;
    inr_q  <= inr_d;
  end

  always_comb begin
    state_d = state_q;
    t_d     = t_q;
    seg_d   = seg_q;
    acc_d   = acc_q;
    dw_d    = dw_q;
    rem_d   = rem_q;
    qp_d    = qp_q;
    step_d  = step_q;
    duty_d  = duty_q;
    inr_d   = inr_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          t_d     = temperature_i;
          seg_d   = '0;
          state_d = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!seg_ok) begin
          duty_d  = '0;
          inr_d   = 1'b0;
          state_d = ST_DONE;
        end else if (bracket) begin
          inr_d = 1'b1;
          dw_d  = dx;
          if (dx == '0) begin
            // flat segment takes its first value
            duty_d  = (y1 <= 0) ? '0 : DUTY_W'({y1[Y_W-2:0], 8'b0});
            state_d = ST_DONE;
          end else begin
            state_d = ST_MUL1;
          end
        end else begin
          seg_d = seg_nx;
        end
      end
      ST_MUL1: begin
        acc_d   = mul_p;
        state_d = ST_MUL2;
      end
      ST_MUL2: begin
        acc_d   = acc_q + mul_p;
        state_d = ST_PREP;
      end
      ST_PREP: begin
        if (acc_q <= 0) begin
          duty_d  = '0;
          state_d = ST_DONE;
        end else begin
          rem_d   = num[NUM_W-1:DUTY_W];
          qp_d    = num[DUTY_W-1:0];
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_d  = q_bit ? DIV_W'(trial - {1'b0, dvs}) : trial[DIV_W-1:0];
        qp_d   = {qp_q[DUTY_W-2:0], q_bit};
        step_d = step_q + STEP_W'(1);
        if (step_q == DIV_STEPS - STEP_W'(1)) begin
          duty_d  = (qp_d > FULL_SCALE) ? FULL_SCALE : qp_d;
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign busy_o      = state_q != ST_IDLE;
  assign done_o      = state_q == ST_DONE;
  assign fan_duty_o  = duty_q;
  assign in_range_o  = inr_q;
  assign cfg_ready_o = 1'b1;

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_o && !done_o)
    else $error("result strobe not followed by idle");

  a_miss_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !in_range_o) |-> (fan_duty_o == '0))
    else $error("out of range result not zero");

  a_duty_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (fan_duty_o <= FULL_SCALE))
    else $error("duty above full scale");

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fan curve interpolator. A directed table covers
// reset, field extremes, short and oversized point counts, zero-width and
// descending segments and speeds above full scale. Random curves follow, each
// exercised with temperatures mostly clustered on the curve points. Every
// word is checked against the in-bench interpolation model or a table value.
// ----------------------------------------------------------------------------
module tb_top;
  import fci_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int RESET_TICKS = 4;
  localparam int PHASES      = 38;
  localparam int PHASE_ITEMS = 50;
  localparam int TAIL_TICKS  = 30;
  localparam int LIMIT_TICKS = 500000;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              in_range;
  } fan_word_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [1:0]        index;
    logic [63:0]       data;
    logic [TEMP_W-1:0] temp;
    logic              typed;
    fan_word_t         word;
  } row_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              start_i       = 1'b0;
  logic [TEMP_W-1:0] temperature_i = '0;
  logic              cfg_valid_i   = 1'b0;
  logic [1:0]        cfg_index_i   = '0;
  logic [63:0]       cfg_data_i    = '0;
  logic              busy_o;
  logic              done_o;
  logic [DUTY_W-1:0] fan_duty_o;
  logic              in_range_o;
  logic              cfg_ready_o;

  logic [CNT_W-1:0]  curve_count;
  logic [63:0]       curve_temps;
  logic [63:0]       curve_speeds;

  fan_word_t pending_duty[$];
  fan_word_t oldest_word;
  int        mismatch_count = 0;
  int        tick_count     = 0;
  bit        gaps_on        = 1'b1;

  fan_curve_interpolator u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .temperature_i (temperature_i),
    .done_o        (done_o),
    .fan_duty_o    (fan_duty_o),
    .in_range_o    (in_range_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #CLK_HALF clk_i = ~clk_i;

  function automatic fan_word_t predict_duty(input logic [TEMP_W-1:0] temp);
    fan_word_t   w;
    int unsigned n;
    longint      t, x1, x2, s1, s2, y1, y2, d, num, q;
    bit          found;
    w     = '0;
    found = 1'b0;
    t     = temp;
    n     = curve_count;
    if (n > MAX_POINTS) begin
      n = MAX_POINTS;
    end
    for (int i = 0; i + 1 < n && !found; i++) begin
      x1 = curve_temps[8*i +: 8];
      x2 = curve_temps[8*(i+1) +: 8];
      s1 = curve_speeds[8*i +: 8];
      s2 = curve_speeds[8*(i+1) +: 8];
      x1 = x1 * 16;
      x2 = x2 * 16;
      y1 = 100 - s1;
      y2 = 100 - s2;
      if (x1 <= t && t <= x2) begin
        found      = 1'b1;
        w.in_range = 1'b1;
        d          = x2 - x1;
        if (d == 0) begin
          q = y1 * 256;
        end else begin
          num = 256 * (y1 * (x2 - t) + y2 * (t - x1));
          q   = (num <= 0) ? 0 : (2 * num + d) / (2 * d);
        end
        if (q < 0) begin
          q = 0;
        end
        if (q > FULL_SCALE) begin
          q = FULL_SCALE;
        end
        w.duty = DUTY_W'(q);
      end
    end
    return w;
  endfunction

  task automatic write_reg(input logic [1:0] index, input logic [63:0] data);
    if (gaps_on && $urandom_range(99) < 9) begin
      cfg_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_POINT_COUNT:  curve_count  = data[CNT_W-1:0];
      REG_CURVE_TEMPS:  curve_temps  = data;
      REG_CURVE_SPEEDS: curve_speeds = data;
      default: ;
    endcase
  endtask

  task automatic send_sample(input logic [TEMP_W-1:0] temp, input bit typed,
                             input fan_word_t typed_word);
    if (gaps_on && $urandom_range(99) < 9) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    temperature_i <= temp;
    do @(posedge clk_i); while (busy_o);
    pending_duty.push_back(typed ? typed_word : predict_duty(temp));
  endtask

  task automatic drain;
    while (pending_duty.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic random_curve(output logic [CNT_W-1:0] cnt, output logic [63:0] temps,
                              output logic [63:0] speeds);
    int pt;
    pt = $urandom_range(0, 60);
    if ($urandom_range(0, 7) == 0) begin
      cnt    = CNT_W'($urandom_range(0, 15));
      temps  = {$urandom, $urandom};
      speeds = {$urandom, $urandom};
    end else begin
      cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 15))
                                        : CNT_W'($urandom_range(2, MAX_POINTS));
      for (int i = 0; i < MAX_POINTS; i++) begin
        temps[8*i +: 8]  = 8'(pt);
        speeds[8*i +: 8] = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(101, 255))
                                                        : 8'($urandom_range(0, 100));
        pt = pt + (($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40));
        if (pt > 255) begin
          pt = 255;
        end
      end
    end
  endtask

  function automatic logic [TEMP_W-1:0] pick_temp();
    int v;
    if ($urandom_range(0, 9) < 3) begin
      v = $urandom_range(0, 4095);
    end else begin
      v = curve_temps[8*$urandom_range(0, 7) +: 8];
      v = v * 16 + $urandom_range(0, 40) - 20;
      if (v < 0) begin
        v = 0;
      end
      if (v > 4095) begin
        v = 4095;
      end
    end
    return TEMP_W'(v);
  endfunction

  function automatic row_t wr(input logic [1:0] index, input logic [63:0] data);
    return '{kind: ROW_WRITE, index: index, data: data, default: '0};
  endfunction

  function automatic row_t smp(input logic [TEMP_W-1:0] temp, input bit typed,
                               input int duty, input bit in_range);
    row_t r;
    r            = '0;
    r.kind       = ROW_SAMPLE;
    r.temp       = temp;
    r.typed      = typed;
    r.word.duty  = DUTY_W'(duty);
    r.word.in_range = in_range;
    return r;
  endfunction

  // result side: one word per strobe, no back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_duty.size() == 0) begin
        $display("%0t: unexpected word fan_duty=%0d in_range=%0b",
                 $time, fan_duty_o, in_range_o);
        mismatch_count++;
      end else begin
        oldest_word = pending_duty.pop_front();
        if (fan_duty_o !== oldest_word.duty) begin
          $display("%0t: fan_duty expected %0d actual %0d",
                   $time, oldest_word.duty, fan_duty_o);
          mismatch_count++;
        end
        if (in_range_o !== oldest_word.in_range) begin
          $display("%0t: in_range expected %0b actual %0b",
                   $time, oldest_word.in_range, in_range_o);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    tick_count <= tick_count + 1;
    if (tick_count == LIMIT_TICKS) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    row_t             directed_rows[$];
    logic [CNT_W-1:0] cnt;
    logic [63:0]      temps;
    logic [63:0]      speeds;

    curve_count  = '0;
    curve_temps  = '0;
    curve_speeds = '0;

    // reset state: no points
    directed_rows.push_back(smp(12'd0, 1, 0, 0));
    directed_rows.push_back(smp(12'hFFF, 1, 0, 0));
    // four points, 20..80 degrees, speeds 100, 70, 40, 0
    directed_rows.push_back(wr(REG_CURVE_TEMPS, 64'h0000_0000_503C_2814));
    directed_rows.push_back(wr(REG_CURVE_SPEEDS, 64'h0000_0000_0028_4664));
    directed_rows.push_back(wr(REG_POINT_COUNT, 64'd4));
    directed_rows.push_back(smp(12'd320, 1, 0, 1));
    directed_rows.push_back(smp(12'd1280, 1, 25600, 1));
    directed_rows.push_back(smp(12'd960, 1, 15360, 1));
    directed_rows.push_back(smp(12'd319, 1, 0, 0));
    directed_rows.push_back(smp(12'd1281, 1, 0, 0));
    directed_rows.push_back(smp(12'd800, 0, 0, 0));
    // single point gives no segment, two points the shortest curve
    directed_rows.push_back(wr(REG_POINT_COUNT, 64'd1));
    directed_rows.push_back(smp(12'd320, 1, 0, 0));
    directed_rows.push_back(wr(REG_POINT_COUNT, 64'd2));
    directed_rows.push_back(smp(12'd480, 0, 0, 0));
    // oversized count, zero-width start, descending segment, speeds over 100
    directed_rows.push_back(wr(REG_CURVE_TEMPS, 64'hFFFF_FFFF_5A64_0000));
    directed_rows.push_back(wr(REG_CURVE_SPEEDS, 64'h0000_0000_32FF_C81E));
    directed_rows.push_back(wr(REG_POINT_COUNT, 64'd15));
    directed_rows.push_back(smp(12'd0, 1, 17920, 1));
    directed_rows.push_back(smp(12'd16, 1, 0, 1));
    directed_rows.push_back(smp(12'd1520, 1, 0, 1));
    directed_rows.push_back(smp(12'd4080, 1, 25600, 1));
    directed_rows.push_back(smp(12'hFFF, 1, 0, 0));
    directed_rows.push_back(smp(12'd1700, 0, 0, 0));
    // unmapped index leaves the curve alone
    directed_rows.push_back(wr(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(smp(12'd1700, 0, 0, 0));
    // all ones
    directed_rows.push_back(wr(REG_CURVE_TEMPS, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(wr(REG_CURVE_SPEEDS, 64'hFFFF_FFFF_FFFF_FFFF));
    directed_rows.push_back(wr(REG_POINT_COUNT, 64'd8));
    directed_rows.push_back(smp(12'd4080, 1, 0, 1));
    directed_rows.push_back(smp(12'd0, 1, 0, 0));

    repeat (RESET_TICKS) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        start_i <= 1'b0;
        drain();
        write_reg(directed_rows[k].index, directed_rows[k].data);
      end else begin
        cfg_valid_i <= 1'b0;
        send_sample(directed_rows[k].temp, directed_rows[k].typed, directed_rows[k].word);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      start_i     <= 1'b0;
      cfg_valid_i <= 1'b0;
      drain();
      gaps_on = (p < 12 || p > 19);
      random_curve(cnt, temps, speeds);
      write_reg(REG_CURVE_TEMPS, temps);
      write_reg(REG_CURVE_SPEEDS, speeds);
      if ($urandom_range(0, 5) == 0) begin
        write_reg(REG_UNUSED, {$urandom, $urandom});
      end
      write_reg(REG_POINT_COUNT, {$urandom, 28'(0), cnt});
      cfg_valid_i <= 1'b0;
      for (int j = 0; j < PHASE_ITEMS; j++) begin
        if (gaps_on && $urandom_range(0, 59) == 0) begin
          start_i <= 1'b0;
          drain();
        end
        send_sample(pick_temp(), 1'b0, '0);
      end
    end

    start_i <= 1'b0;
    while (pending_duty.size() != 0) @(posedge clk_i);
    repeat (TAIL_TICKS) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[sim.f]
src/fci_pkg.sv
src/fan_curve_interpolator.sv
sim/tb_top.sv
